// ===== src/ict_pkg.sv =====
// ict_pkg: shared types and codes for the idle connection timeout table
// no dependencies; used by ict_entry_ram and idle_connection_timeout_table
package ict_pkg;

  // request codes on in_func
  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_SCHEDULE = 2'd1;
  localparam logic [1:0] FUNC_UPDATE   = 2'd2;

  // result codes on out_kind
  localparam logic [2:0] KIND_EXPIRED   = 3'd0;
  localparam logic [2:0] KIND_APPENDED  = 3'd1;
  localparam logic [2:0] KIND_REFRESHED = 3'd2;
  localparam logic [2:0] KIND_FULL      = 3'd3;
  localparam logic [2:0] KIND_NONE      = 3'd4;

  // one table entry
  typedef struct packed {
    logic [15:0] handle;
    logic [31:0] deadline;
  } entry_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_APPEND,
    S_TICK_END
  } state_t;

endpackage

// ===== src/ict_entry_ram.sv =====
// ict_entry_ram: entry store, one write port and one registered read port
// depends on ict_pkg (entry_t)
module ict_entry_ram import ict_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/idle_connection_timeout_table.sv =====
// idle_connection_timeout_table: table of connection handles with deadlines
// depends on ict_pkg and ict_entry_ram
//
//   channel | direction | ports                                  | handshake
//   in      | input     | in_func, in_handle, in_timeout_seconds | in_valid / in_ready
//   out     | output    | out_kind, out_handle_res, out_last     | out_valid / out_ready
//
// a schedule appends once the output is free; a tick or update scans the table
// with one ram read port and one comparator, taking each entry in turn
// through a read state and a check state
// reset clears state, time, entry count and valid flags; no entry is read unset
// in_ready is high only in idle; an out stall can hold the scan
module idle_connection_timeout_table import ict_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_handle,
  input  logic [15:0] in_timeout_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [15:0] out_handle_res,
  output logic        out_last
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  // sequencer and operation registers
  state_t        state_r, state_nxt;
  logic [1:0]    op_func_r, op_func_nxt;
  logic [15:0]   op_handle_r, op_handle_nxt;
  logic [31:0]   op_deadline_r, op_deadline_nxt;
  logic [31:0]   now_r, now_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] keep_r, keep_nxt;
  // expired handle held back until we know whether it is the last one
  logic          pend_valid_r, pend_valid_nxt;
  logic [15:0]   pend_handle_r, pend_handle_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_kind_r, out_kind_nxt;
  logic [15:0]   out_handle_r, out_handle_nxt;
  logic          out_last_r, out_last_nxt;

  // ram port
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  entry_t        rd_data;

  logic          out_free;
  logic          scan_end;
  logic          expired;

  ict_entry_ram #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_handle_res = out_handle_r;
  assign out_last       = out_last_r;

  // output slot can take a new result this cycle
  assign out_free = !out_valid_r || out_ready;
  // entry being checked is the last one in the table
  assign scan_end = ((CW'(idx_r) + CW'(1)) == count_r);
  // plain unsigned compare, no wrap correction
  assign expired  = (rd_data.deadline <= now_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      now_r        <= '0;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      now_r        <= now_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_func_r     <= op_func_nxt;
    op_handle_r   <= op_handle_nxt;
    op_deadline_r <= op_deadline_nxt;
    idx_r         <= idx_nxt;
    keep_r        <= keep_nxt;
    pend_handle_r <= pend_handle_nxt;
    out_kind_r    <= out_kind_nxt;
    out_handle_r  <= out_handle_nxt;
    out_last_r    <= out_last_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    op_func_nxt     = op_func_r;
    op_handle_nxt   = op_handle_r;
    op_deadline_nxt = op_deadline_r;
    now_nxt         = now_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    keep_nxt        = keep_r;
    pend_valid_nxt  = pend_valid_r;
    pend_handle_nxt = pend_handle_r;

    // result leaves when taken
    out_valid_nxt   = out_valid_r && !out_ready;
    out_kind_nxt    = out_kind_r;
    out_handle_nxt  = out_handle_r;
    out_last_nxt    = out_last_r;

    wr_en           = 1'b0;
    wr_addr         = keep_r[AW-1:0];
    wr_data         = rd_data;
    rd_en           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_func_nxt     = in_func;
          op_handle_nxt   = in_handle;
          // deadline counts from the time before any tick advance
          op_deadline_nxt = now_r + 32'(in_timeout_seconds);
          idx_nxt         = '0;
          keep_nxt        = '0;
          pend_valid_nxt  = 1'b0;
          case (in_func)
            FUNC_TICK: begin
              now_nxt   = now_r + 32'd1;
              state_nxt = (count_r == '0) ? S_TICK_END : S_READ;
            end
            FUNC_SCHEDULE: begin
              state_nxt = S_APPEND;
            end
            FUNC_UPDATE: begin
              state_nxt = (count_r == '0) ? S_APPEND : S_READ;
            end
            default: begin
              // unused code: dropped, no result
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        if (op_func_r == FUNC_TICK) begin
          if (!(expired && pend_valid_r && !out_free)) begin
            if (expired) begin
              // older expired handle is now known not to be last
              if (pend_valid_r) begin
                out_valid_nxt  = 1'b1;
                out_kind_nxt   = KIND_EXPIRED;
                out_handle_nxt = pend_handle_r;
                out_last_nxt   = 1'b0;
              end
              pend_valid_nxt  = 1'b1;
              pend_handle_nxt = rd_data.handle;
            end else begin
              // survivor moves down to close the gap
              wr_en    = 1'b1;
              wr_addr  = keep_r[AW-1:0];
              wr_data  = rd_data;
              keep_nxt = keep_r + CW'(1);
            end
            if (scan_end) begin
              state_nxt = S_TICK_END;
            end else begin
              idx_nxt   = idx_r + AW'(1);
              state_nxt = S_READ;
            end
          end
        end else begin
          if (rd_data.handle == op_handle_r) begin
            // first match gets the new deadline
            if (out_free) begin
              wr_en           = 1'b1;
              wr_addr         = idx_r;
              wr_data.handle   = op_handle_r;
              wr_data.deadline = op_deadline_r;
              out_valid_nxt   = 1'b1;
              out_kind_nxt    = KIND_REFRESHED;
              out_handle_nxt  = op_handle_r;
              out_last_nxt    = 1'b1;
              state_nxt       = S_IDLE;
            end
          end else if (scan_end) begin
            state_nxt = S_APPEND;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_READ;
          end
        end
      end

      S_APPEND: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_handle_nxt = op_handle_r;
          out_last_nxt   = 1'b1;
          if (count_r == CW'(TABLE_ENTRIES)) begin
            out_kind_nxt = KIND_FULL;
          end else begin
            wr_en            = 1'b1;
            wr_addr          = count_r[AW-1:0];
            wr_data.handle   = op_handle_r;
            wr_data.deadline = op_deadline_r;
            count_nxt        = count_r + CW'(1);
            out_kind_nxt     = KIND_APPENDED;
          end
          state_nxt = S_IDLE;
        end
      end

      S_TICK_END: begin
        if (out_free) begin
          count_nxt     = keep_r;
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (pend_valid_r) begin
            out_kind_nxt   = KIND_EXPIRED;
            out_handle_nxt = pend_handle_r;
          end else begin
            out_kind_nxt   = KIND_NONE;
            out_handle_nxt = '0;
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // table never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  // a checked entry always lies inside the table
  a_idx_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (CW'(idx_r) < count_r))
    else $error("scan index outside table");

  // compaction never writes ahead of the read point
  a_keep_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (keep_r <= CW'(idx_r)))
    else $error("compaction write ahead of scan");

  // a tick transaction advances the clock by exactly one second
  a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func == FUNC_TICK) |=> (now_r == $past(now_r) + 32'd1))
    else $error("tick did not advance time by one");

  // a result is loaded only when the output slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_handle_r)))
    else $error("pending result overwritten");
`endif

endmodule

// ===== tb/idle_connection_timeout_table_test.sv =====
// self-checking testbench for idle_connection_timeout_table: directed and random
// schedule, update and tick traffic against a built-in table predictor
// depends on ict_pkg and the idle_connection_timeout_table rtl
module idle_connection_timeout_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ict_pkg::*;

  localparam int         TABLE_ENTRIES = 64;
  localparam logic [1:0] FUNC_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS  = 140;
  localparam int         CALM_TAIL     = 40;
  localparam int         LONG_HOLD     = 300;
  // a full scan takes every entry through a read and a check state, so this covers any trailing work
  localparam int         DRAIN_CYCLES  = 2 * TABLE_ENTRIES + 20;

  // one request as queued for the driver
  typedef struct {
    logic [1:0]  func;
    logic [15:0] handle;
    logic [15:0] secs;
    bit          drain;  // hold this one back until every result is in
    bit          hold;   // start the long receiver hold-off when it is taken
  } conn_req_t;

  // one result as the block should report it
  typedef struct {
    logic [2:0]  kind;
    logic [15:0] handle;
    logic        last;
  } conn_result_t;

  logic        clk                = 1'b0;
  logic        rst_n              = 1'b0;
  logic        in_valid           = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func            = FUNC_TICK;
  logic [15:0] in_handle          = 16'h0;
  logic [15:0] in_timeout_seconds = 16'h0;
  logic        out_valid;
  logic        out_ready          = 1'b0;
  logic [2:0]  out_kind;
  logic [15:0] out_handle_res;
  logic        out_last;

  // stimulus and expectation stores
  conn_req_t    conn_reqs[$];
  conn_result_t awaited_results[$];
  conn_req_t    on_bus;

  // predictor state: live table in insertion order plus the seconds clock
  logic [31:0] now_secs = 32'd0;
  logic [15:0] live_handle[$];
  logic [31:0] live_deadline[$];

  // handshake bookkeeping between the clocked processes
  bit in_taken    = 1'b0;
  bit rx_hold_req = 1'b0;
  int rx_hold_cnt = 0;
  int rx_gap      = 0;
  int tx_gap      = 0;

  // run statistics
  int err_count    = 0;
  int n_accepted   = 0;
  int n_checked    = 0;
  int n_dropped    = 0;
  int widest_burst = 0;

  idle_connection_timeout_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_handle         (in_handle),
    .in_timeout_seconds(in_timeout_seconds),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_handle_res    (out_handle_res),
    .out_last          (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // queue one expected result at the back
  function automatic void expect_result(input logic [2:0] kind, input logic [15:0] h,
                                        input logic last);
    conn_result_t res;
    res.kind   = kind;
    res.handle = h;
    res.last   = last;
    awaited_results.insert(awaited_results.size(), res);
  endfunction

  // append, or drop and flag when the table is already full
  function automatic void append_entry(input logic [15:0] h, input logic [31:0] deadline);
    if (live_handle.size() >= TABLE_ENTRIES) begin
      expect_result(KIND_FULL, h, 1'b1);
      n_dropped++;
    end else begin
      live_handle.insert(live_handle.size(), h);
      live_deadline.insert(live_deadline.size(), deadline);
      expect_result(KIND_APPENDED, h, 1'b1);
    end
  endfunction

  // work out the results of one accepted transaction and advance the table
  function automatic void predict_conn_step(input conn_req_t r);
    logic [31:0] deadline;
    logic [15:0] keep_h[$];
    logic [31:0] keep_d[$];
    int          expired;
    int          hit;
    deadline = now_secs + 32'(r.secs);
    expired  = 0;
    hit      = -1;
    case (r.func)
      FUNC_TICK: begin
        now_secs = now_secs + 32'd1;
        // plain unsigned compare, expired entries reported in table order
        foreach (live_handle[i]) begin
          if (live_deadline[i] <= now_secs) begin
            expect_result(KIND_EXPIRED, live_handle[i], 1'b0);
            expired++;
          end else begin
            keep_h.insert(keep_h.size(), live_handle[i]);
            keep_d.insert(keep_d.size(), live_deadline[i]);
          end
        end
        live_handle   = keep_h;
        live_deadline = keep_d;
        if (expired == 0) begin
          expect_result(KIND_NONE, 16'h0, 1'b1);
        end else begin
          awaited_results[awaited_results.size() - 1].last = 1'b1;
        end
        if (expired > widest_burst) widest_burst = expired;
      end
      FUNC_SCHEDULE: append_entry(r.handle, deadline);
      FUNC_UPDATE: begin
        // only the first matching entry is refreshed
        foreach (live_handle[i]) begin
          if (hit < 0 && live_handle[i] == r.handle) hit = i;
        end
        if (hit >= 0) begin
          live_deadline[hit] = deadline;
          expect_result(KIND_REFRESHED, r.handle, 1'b1);
        end else begin
          append_entry(r.handle, deadline);
        end
      end
      default: ;  // unused code, no state change and no result
    endcase
  endfunction

  function automatic void add_req(input logic [1:0] f, input logic [15:0] h,
                                  input logic [15:0] s, input bit drain = 1'b0,
                                  input bit hold = 1'b0);
    conn_req_t req;
    req.func   = f;
    req.handle = h;
    req.secs   = s;
    req.drain  = drain;
    req.hold   = hold;
    conn_reqs.insert(conn_reqs.size(), req);
  endfunction

  // driver: new payload at the falling edge, held until the transaction is taken
  always @(negedge clk) begin
    conn_req_t nxt;
    logic      drive;
    drive = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      in_taken = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (conn_reqs.size() > 0) begin
        if (conn_reqs[0].drain && awaited_results.size() != 0) begin
          // sender pause: wait for the block to hand back everything
        end else if (conn_reqs.size() >= CALM_TAIL && $urandom_range(0, 99) < 20) begin
          tx_gap = $urandom_range(1, 10) - 1;
        end else begin
          nxt                = conn_reqs.pop_front();
          on_bus             = nxt;
          in_func            <= nxt.func;
          in_handle          <= nxt.handle;
          in_timeout_seconds <= nxt.secs;
          drive              = 1'b1;
        end
      end
      in_valid <= drive;
    end
  end

  // receiver: random short stalls, one long hold-off, always ready near the end
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold_cnt > 0) begin
      rx_hold_cnt--;
      out_ready <= 1'b0;
    end else if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_hold_cnt = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else if (conn_reqs.size() >= CALM_TAIL && $urandom_range(0, 99) < 15) begin
      rx_gap = $urandom_range(1, 10) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: sample both channels at the rising edge, predict then check
  always @(posedge clk) begin
    conn_req_t    taken;
    conn_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        taken        = on_bus;
        taken.func   = in_func;
        taken.handle = in_handle;
        taken.secs   = in_timeout_seconds;
        in_taken     = 1'b1;
        n_accepted++;
        if (taken.hold) rx_hold_req = 1'b1;
        predict_conn_step(taken);
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result with no transaction awaiting it: kind %0d handle %h last %0d",
                 out_kind, out_handle_res, out_last);
          err_count++;
        end else begin
          want = awaited_results.pop_front();
          n_checked++;
          if (out_kind !== want.kind) begin
            $error("out_kind: expected %0d, actual %0d", want.kind, out_kind);
            err_count++;
          end
          if (out_handle_res !== want.handle) begin
            $error("out_handle_res: expected %h, actual %h", want.handle, out_handle_res);
            err_count++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0d, actual %0d", want.last, out_last);
            err_count++;
          end
        end
      end
    end
  end

  // stimulus build, reset, and end of run
  initial begin
    logic [15:0] handle_pool[8];
    logic [15:0] fill_h[TABLE_ENTRIES];
    logic [1:0]  f;
    logic [15:0] h;
    logic [15:0] s;
    int          counted;
    int          pick;
    int          roll;

    // directed: empty tick, field extremes, duplicates, refresh, zero timeout
    add_req(FUNC_TICK,     16'h0000, 16'h0000);
    add_req(FUNC_SCHEDULE, 16'h0000, 16'h0000);
    add_req(FUNC_SCHEDULE, 16'hffff, 16'hffff);
    add_req(FUNC_SCHEDULE, 16'h1234, 16'h0002);
    add_req(FUNC_SCHEDULE, 16'h1234, 16'h0005);
    add_req(FUNC_UPDATE,   16'h1234, 16'h0001);
    add_req(FUNC_UPDATE,   16'habcd, 16'h0003);
    add_req(FUNC_UNUSED,   16'h5555, 16'haaaa);
    add_req(FUNC_TICK,     16'hffff, 16'hffff);
    // pull the long-lived entry back so the table can empty
    add_req(FUNC_UPDATE,   16'hffff, 16'h0000);
    add_req(FUNC_TICK,     16'h0000, 16'h0000);
    add_req(FUNC_TICK,     16'h0000, 16'h0000);
    add_req(FUNC_TICK,     16'h0000, 16'h0000);
    add_req(FUNC_TICK,     16'h0000, 16'h0000);
    add_req(FUNC_UNUSED,   16'haaaa, 16'h5555);

    // fill the table to the brim behind a drained pipe, with a long receiver hold
    foreach (fill_h[i]) begin
      fill_h[i] = 16'($urandom);
      add_req(FUNC_SCHEDULE, fill_h[i], 16'd2, i == 0, i == 3);
    end
    add_req(FUNC_SCHEDULE, 16'($urandom), 16'd2);
    add_req(FUNC_SCHEDULE, 16'($urandom), 16'($urandom));
    add_req(FUNC_UPDATE,   16'($urandom), 16'd2);
    // refresh while full keeps the same deadline, so the second tick expires everything
    add_req(FUNC_UPDATE,   fill_h[10], 16'd2);
    add_req(FUNC_TICK,     16'h0000, 16'h0000);
    add_req(FUNC_TICK,     16'h0000, 16'h0000);

    // random traffic: mostly a small handle pool and short timeouts
    foreach (handle_pool[i]) handle_pool[i] = 16'($urandom);
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      roll = $urandom_range(0, 99);
      h    = ($urandom_range(0, 99) < 70) ? handle_pool[$urandom_range(0, 7)]
                                           : 16'($urandom);
      s    = (roll < 80) ? 16'($urandom_range(0, 8)) :
             (roll < 95) ? 16'($urandom_range(9, 200)) : 16'($urandom);
      if (pick < 5) begin
        add_req(FUNC_UNUSED, 16'($urandom), 16'($urandom));
      end else begin
        f = (pick < 38) ? FUNC_SCHEDULE : (pick < 68) ? FUNC_UPDATE : FUNC_TICK;
        add_req(f, h, s, counted == RANDOM_ITEMS / 2);
        counted++;
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (conn_reqs.size() == 0 && !in_valid);
    wait (awaited_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d transactions in and %0d results out", n_accepted, n_checked);
    $display("table-full drops %0d, largest expiry burst %0d entries", n_dropped,
             widest_burst);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog for a hung handshake or a missing result
  initial begin
    #3000000;
    $display("timeout with %0d results still awaited", awaited_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
